FILE: rtl/core/pkcf_pkg.sv
// Shared types and constants for the per-key cooldown filter.
`default_nettype none
package pkcf_pkg;

  // Packed stream widths, whole bytes, and configuration port widths
  localparam int unsigned IN_TDATA_W  = 120;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  // reciprocals, rounded up: x / d = (x * RECIP) >> shift over the whole input range
  localparam logic [25:0] DAY_RECIP   = 26'd50903317;  // 2^35 / 675, upper 25 bits of secs
  localparam logic [17:0] HOUR_RECIP  = 18'd149131;    // 2^29 / 3600
  localparam logic [12:0] MIN_RECIP   = 13'd4370;      // 2^18 / 60
  localparam logic [2:0]  TOD_LATENCY = 3'd7;

  localparam logic [CFG_INDEX_W-1:0] CFG_DIRECT_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COOLDOWN    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZONE_OFFSET = 2'd2;

  localparam logic [31:0] COOLDOWN_RESET = 32'd300;

  typedef enum logic [2:0] {
    OUT_SENT      = 3'd0,
    OUT_MODE_OFF  = 3'd1,
    OUT_LINK_DOWN = 3'd2,
    OUT_NO_CLOCK  = 3'd3,
    OUT_COOLDOWN  = 3'd4,
    OUT_REFUSED   = 3'd5
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } top_state_t;

  typedef struct packed {
    logic       done;
    logic [4:0] hour;
    logic [5:0] minute;
  } tod_res_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [15:0] key_high;
    logic [63:0] key_low;
  } entry_t;

endpackage
`default_nettype wire

FILE: rtl/core/per_key_cooldown_filter_top.sv
// Per-card cooldown filter: table scan in a single-port memory plus time-of-day unit.
// A tap refused for mode off, link down or a zero clock goes straight from the request to
// the finishing state, which loads its result. Any other tap walks the table, reading one
// entry a cycle from the synchronous memory, while the time-of-day unit works out hour and
// minute from the same request. The scan is left once the walk is complete and hour and
// minute are ready, and a finishing state then loads the result; it waits there while the
// output register is still full and not taken. The table is cleared at reset through
// per-entry valid bits, so no clearing pass is needed. The result sits in an output
// register, so a new tap is taken while the last result waits.
`default_nettype none
module per_key_cooldown_filter_top #(
  parameter int unsigned TABLE_ENTRIES = 12
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata: card_key_low[63:0], card_key_high[79:64], now_seconds[111:80],
  //           link_ready[112], queue_accepts[113], zero pad [119:114]
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [pkcf_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata: notified[0], outcome[3:1], local_hour[8:4], local_minute[14:9], zero pad [15]
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [pkcf_pkg::OUT_TDATA_W-1:0]        out_tdata,
  input  wire logic                               cfg_wr_en,
  input  wire logic [pkcf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [pkcf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import pkcf_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  // configuration
  logic        direct_mode_r;
  logic [31:0] cooldown_r;
  logic [17:0] zone_r;

  // request fields
  logic [63:0] in_key_low;
  logic [15:0] in_key_high;
  logic [31:0] in_now;
  logic        in_link;
  logic        in_accepts;
  logic        in_fire;

  // held request
  logic [63:0] key_low_r;
  logic [15:0] key_high_r;
  logic [31:0] now_r;
  logic        accepts_r;
  logic        early_r;
  outcome_t    early_code_r;

  logic        early_w;
  outcome_t    early_code_w;
  logic [31:0] local_w;

  top_state_t  state_r, state_nxt;

  // table memory
  entry_t                   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  entry_t                   rd_entry_r;
  logic                     rd_valid_r;
  logic                     rd_pend_r;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic                     mem_we;
  logic [CNT_W-1:0]         issue_cnt_r;
  logic [IDX_W-1:0]         ptr_r;
  logic                     hit_r;
  logic                     match;
  logic                     scan_done;
  logic [31:0]              age;

  tod_res_t    tod_res;
  logic        tod_start;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_free;
  logic                   out_load;
  logic                   res_notified;
  outcome_t               res_outcome;
  logic [4:0]             res_hour;
  logic [5:0]             res_minute;

  assign in_key_low  = in_tdata[63:0];
  assign in_key_high = in_tdata[79:64];
  assign in_now      = in_tdata[111:80];
  assign in_link     = in_tdata[112];
  assign in_accepts  = in_tdata[113];
  assign in_fire     = in_tvalid && in_tready;

  always_comb begin
    early_w      = 1'b1;
    early_code_w = OUT_MODE_OFF;
    if (!direct_mode_r) begin
      early_code_w = OUT_MODE_OFF;
    end else if (!in_link) begin
      early_code_w = OUT_LINK_DOWN;
    end else if (in_now == 32'd0) begin
      early_code_w = OUT_NO_CLOCK;
    end else begin
      early_w = 1'b0;
    end
  end

  assign local_w = in_now + {{14{zone_r[17]}}, zone_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direct_mode_r <= 1'b1;
      cooldown_r    <= COOLDOWN_RESET;
      zone_r        <= 18'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DIRECT_MODE: direct_mode_r <= cfg_wdata[0];
        CFG_COOLDOWN:    cooldown_r    <= cfg_wdata;
        CFG_ZONE_OFFSET: zone_r        <= cfg_wdata[17:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = early_w ? ST_FINISH : ST_SCAN;
      ST_SCAN:   if (scan_done && tod_res.done) state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    rd_en     = (state_r == ST_SCAN) && (issue_cnt_r != CNT_LAST);
    out_load  = (state_r == ST_FINISH) && out_free;
    tod_start = in_fire && !early_w;
  end

  assign out_free  = !out_valid_r || out_tready;
  assign rd_addr   = issue_cnt_r[IDX_W-1:0];
  assign scan_done = (issue_cnt_r == CNT_LAST) && !rd_pend_r;
  assign mem_we    = out_load && !early_r && !hit_r && accepts_r;

  assign age   = now_r - rd_entry_r.stamp;
  assign match = rd_valid_r && (rd_entry_r.stamp != 32'd0) &&
                 (rd_entry_r.key_low == key_low_r) && (rd_entry_r.key_high == key_high_r) &&
                 (age < cooldown_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      ptr_r       <= '0;
      rd_pend_r   <= 1'b0;
      issue_cnt_r <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_en;
      if (in_fire) begin
        issue_cnt_r <= '0;
        hit_r       <= 1'b0;
      end else begin
        if (rd_en) issue_cnt_r <= issue_cnt_r + CNT_W'(1);
        if (rd_pend_r && match) hit_r <= 1'b1;
      end
      if (mem_we) begin
        valid_r[ptr_r] <= 1'b1;
        ptr_r          <= (ptr_r == IDX_LAST) ? '0 : (ptr_r + IDX_W'(1));
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_low_r    <= in_key_low;
      key_high_r   <= in_key_high;
      now_r        <= in_now;
      accepts_r    <= in_accepts;
      early_r      <= early_w;
      early_code_r <= early_code_w;
    end
  end

  // single-port table, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ptr_r] <= '{stamp: now_r, key_high: key_high_r, key_low: key_low_r};
    end
    if (rd_en) begin
      rd_entry_r <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  pkcf_tod u_tod (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (tod_start),
    .local_secs (local_w),
    .res        (tod_res)
  );

  always_comb begin
    res_notified = 1'b0;
    res_hour     = 5'd0;
    res_minute   = 6'd0;
    if (early_r) begin
      res_outcome = early_code_r;
    end else if (hit_r) begin
      res_outcome = OUT_COOLDOWN;
    end else begin
      res_hour   = tod_res.hour;
      res_minute = tod_res.minute;
      if (accepts_r) begin
        res_outcome  = OUT_SENT;
        res_notified = 1'b1;
      end else begin
        res_outcome = OUT_REFUSED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {1'b0, res_minute, res_hour, res_outcome, res_notified};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= IDX_LAST)
    else $error("replace pointer beyond table");
  a_notified_sent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[3:1] == OUT_SENT)))
    else $error("notified flag disagrees with outcome");
  a_early_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !direct_mode_r) |=> state_r == ST_FINISH)
    else $error("mode-off request did not go straight to finish");
  a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_FINISH) && scan_done && tod_res.done)
    else $error("table written before scan and time of day complete");
  a_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[3:1] == OUT_MODE_OFF || out_tdata[3:1] == OUT_LINK_DOWN ||
                    out_tdata[3:1] == OUT_NO_CLOCK || out_tdata[3:1] == OUT_COOLDOWN))
      |-> out_tdata[14:4] == 11'd0)
    else $error("time fields set on a refused tap");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/pkcf_tod.sv
// Time-of-day unit: local seconds to hour and minute by reciprocal multiplication.
`default_nettype none
module pkcf_tod (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [31:0]       local_secs,
  output pkcf_pkg::tod_res_t     res
);
  import pkcf_pkg::*;

  logic [31:0] local_r;
  logic [50:0] day_prod_r;
  logic [31:0] day_base_r;
  logic [16:0] day_rem_r;
  logic [34:0] hour_prod_r;
  logic [16:0] hour_base_r;
  logic [11:0] hour_rem_r;
  logic [24:0] min_prod_r;
  logic [2:0]  cnt_r;
  logic        done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 3'd0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= TOD_LATENCY;
      done_r <= 1'b0;
    end else if (cnt_r != 3'd0) begin
      cnt_r  <= cnt_r - 3'd1;
      done_r <= (cnt_r == 3'd1);
    end
  end

  // one multiply or subtract per stage; every stage settles from the held input
  always_ff @(posedge clk) begin
    if (start) local_r <= local_secs;
    // 86400 = 675 * 128, so the day count is the upper 25 bits over 675
    day_prod_r  <= {26'd0, local_r[31:7]} * {25'd0, DAY_RECIP};
    day_base_r  <= {16'd0, day_prod_r[50:35]} * {15'd0, SECS_PER_DAY};
    day_rem_r   <= 17'(local_r - day_base_r);
    hour_prod_r <= {18'd0, day_rem_r} * {17'd0, HOUR_RECIP};
    hour_base_r <= {12'd0, hour_prod_r[33:29]} * SECS_PER_HOUR;
    hour_rem_r  <= 12'(day_rem_r - hour_base_r);
    min_prod_r  <= {13'd0, hour_rem_r} * {12'd0, MIN_RECIP};
  end

  assign res.done   = done_r;
  assign res.hour   = hour_prod_r[33:29];
  assign res.minute = min_prod_r[23:18];

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> cnt_r == 3'd0)
    else $error("time-of-day result flagged while unit busy");
  a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> res.hour < 5'd24 && res.minute < 6'd60)
    else $error("time-of-day result out of range");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> cnt_r == 3'd0)
    else $error("time-of-day unit started while busy");
  a_start_load: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> cnt_r == TOD_LATENCY && !done_r)
    else $error("time-of-day unit did not start counting");
`endif

endmodule
`default_nettype wire
